// ===== rtl/core/vpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vpd_pkg
// Types and constants shared by the varint packet deframer and its channels.
// ----------------------------------------------------------------------------
package vpd_pkg;

  // Varint framing
  localparam int unsigned MAX_VARINT_BYTES = 5;
  localparam int unsigned CNT_W            = 3;
  localparam logic [7:0]  DATA_BITS        = 8'h7F;
  localparam logic [7:0]  MORE_BIT         = 8'h80;

  // Configuration port
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic        REG_FLAG_MASK = 1'b0;   // register index, paddr[2]
  localparam logic [31:0] FLAG_MASK_RST = 32'h0000_0040;

  // Result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_HEADER = 2'd0;
  localparam kind_t KIND_DATA   = 2'd1;
  localparam kind_t KIND_ERROR  = 2'd2;

  // Parser phase
  typedef enum logic [1:0] {
    PH_TYPE,
    PH_TICK,
    PH_SIZE,
    PH_DATA
  } phase_t;

  // One result word
  typedef struct packed {
    kind_t       result_kind;
    logic [31:0] message_type;
    logic        is_compressed;
    logic [31:0] tick_value;
    logic [31:0] payload_size;
    logic [7:0]  data_byte;
    logic        last_of_packet;
  } result_t;

endpackage

// ===== rtl/core/vpd_stream_if.sv =====
// ----------------------------------------------------------------------------
// vpd_stream_if
// Valid/ready channels of the deframer: raw byte in, result word out.
// ----------------------------------------------------------------------------
interface vpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

interface vpd_result_if;
  logic              valid;
  logic              ready;
  vpd_pkg::kind_t    result_kind;
  logic [31:0]       message_type;
  logic              is_compressed;
  logic [31:0]       tick_value;
  logic [31:0]       payload_size;
  logic [7:0]        data_byte;
  logic              last_of_packet;

  modport source (output valid, output result_kind, output message_type,
                  output is_compressed, output tick_value, output payload_size,
                  output data_byte, output last_of_packet, input ready);
  modport sink   (input valid, input result_kind, input message_type,
                  input is_compressed, input tick_value, input payload_size,
                  input data_byte, input last_of_packet, output ready);
endinterface

// ===== rtl/core/varint_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// varint_packet_deframer
// Splits bytes into packets of three base-128 varints (type, tick, size) and
// a payload; emits a header word, one word per payload byte, or error words.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake               Carries
//  in_ch    in   valid/ready             byte_value, one stream byte
//  out_ch   out  valid/ready             header, payload byte or error word
//  cfg      in   APB, pready tied high   compressed_flag_mask at address 0
//
//  One byte is accepted per cycle while the skid is empty. Each result word
//  goes to the output register, or to the skid when that register is full
//  and not popped. The parser state update is a single shift-or and counter
//  step, so throughput is set only by the output side. Output register and
//  skid form a two-entry buffer; in_ch.ready drops only when both are full.
//  Reset is synchronous, active low, and clears parser and buffer control.
//
module varint_packet_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  vpd_byte_if.sink                         in_ch,
  vpd_result_if.source                     out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vpd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [vpd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  // Parser state
  vpd_pkg::phase_t              phase_r, phase_nxt;
  logic [31:0]                  acc_r, acc_nxt;
  logic [vpd_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [31:0]                  type_r, type_nxt;
  logic [31:0]                  tick_r, tick_nxt;
  logic [31:0]                  rem_r, rem_nxt;
  logic [31:0]                  mask_r;

  // Output buffer
  vpd_pkg::result_t             out_r, skid_r;
  logic                         out_valid_r, skid_valid_r;

  // Per-byte working signals
  logic                         in_fire;
  logic [7:0]                   b;
  logic                         more;
  logic [4:0]                   sh;
  logic [31:0]                  acc_or;
  logic [vpd_pkg::CNT_W-1:0]    cnt_inc;
  logic                         overlong;
  logic [31:0]                  rem_dec;
  logic                         res_valid;
  vpd_pkg::result_t             res;
  logic                         out_pop;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_value;
  assign more        = (b & vpd_pkg::MORE_BIT) != 8'h00;
  assign out_pop     = out_valid_r && out_ch.ready;

  // Shift for the current varint byte: 7 bits per byte already taken
  always_comb begin
    case (cnt_r)
      3'd0:    sh = 5'd0;
      3'd1:    sh = 5'd7;
      3'd2:    sh = 5'd14;
      3'd3:    sh = 5'd21;
      3'd4:    sh = 5'd28;
      default: sh = 5'd0;
    endcase
  end

  assign acc_or   = acc_r | (32'(b & vpd_pkg::DATA_BITS) << sh);
  assign cnt_inc  = cnt_r + 3'd1;
  assign overlong = more && (cnt_inc >= vpd_pkg::CNT_W'(vpd_pkg::MAX_VARINT_BYTES));
  assign rem_dec  = (rem_r != 32'd0) ? rem_r - 32'd1 : 32'd0;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (phase_r)
        vpd_pkg::PH_DATA: begin
          if (rem_dec == 32'd0) phase_nxt = vpd_pkg::PH_TYPE;
        end
        vpd_pkg::PH_TYPE: begin
          if (overlong)   phase_nxt = vpd_pkg::PH_TYPE;
          else if (!more) phase_nxt = vpd_pkg::PH_TICK;
        end
        vpd_pkg::PH_TICK: begin
          if (overlong)   phase_nxt = vpd_pkg::PH_TYPE;
          else if (!more) phase_nxt = vpd_pkg::PH_SIZE;
        end
        vpd_pkg::PH_SIZE: begin
          if (overlong) begin
            phase_nxt = vpd_pkg::PH_TYPE;
          end else if (!more) begin
            phase_nxt = (acc_or == 32'd0) ? vpd_pkg::PH_TYPE : vpd_pkg::PH_DATA;
          end
        end
        default: phase_nxt = vpd_pkg::PH_TYPE;
      endcase
    end
  end

  // Datapath and result word
  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    type_nxt  = type_r;
    tick_nxt  = tick_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res       = '0;
    if (in_fire) begin
      if (phase_r == vpd_pkg::PH_DATA) begin
        rem_nxt            = rem_dec;
        res_valid          = 1'b1;
        res.result_kind    = vpd_pkg::KIND_DATA;
        res.data_byte      = b;
        res.last_of_packet = (rem_dec == 32'd0);
      end else if (overlong) begin
        acc_nxt         = 32'd0;
        cnt_nxt         = '0;
        res_valid       = 1'b1;
        res.result_kind = vpd_pkg::KIND_ERROR;
      end else if (more) begin
        acc_nxt = acc_or;
        cnt_nxt = cnt_inc;
      end else begin
        // varint complete
        acc_nxt = 32'd0;
        cnt_nxt = '0;
        case (phase_r)
          vpd_pkg::PH_TYPE: type_nxt = acc_or;
          vpd_pkg::PH_TICK: tick_nxt = acc_or;
          vpd_pkg::PH_SIZE: begin
            rem_nxt            = acc_or;
            res_valid          = 1'b1;
            res.result_kind    = vpd_pkg::KIND_HEADER;
            res.message_type   = type_r & ~mask_r;
            res.is_compressed  = (type_r & mask_r) != 32'd0;
            res.tick_value     = tick_r;
            res.payload_size   = acc_or;
            res.last_of_packet = (acc_or == 32'd0);
          end
          default: ;
        endcase
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= vpd_pkg::PH_TYPE;
      acc_r   <= 32'd0;
      cnt_r   <= '0;
      type_r  <= 32'd0;
      tick_r  <= 32'd0;
      rem_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      type_r  <= type_nxt;
      tick_r  <= tick_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Output register and skid: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      if (!out_valid_r || out_pop) out_valid_r  <= 1'b1;
      else                         skid_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register and skid: payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) out_r <= skid_r;
    end else if (res_valid) begin
      if (!out_valid_r || out_pop) out_r  <= res;
      else                         skid_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_r.result_kind;
  assign out_ch.message_type   = out_r.message_type;
  assign out_ch.is_compressed  = out_r.is_compressed;
  assign out_ch.tick_value     = out_r.tick_value;
  assign out_ch.payload_size   = out_r.payload_size;
  assign out_ch.data_byte      = out_r.data_byte;
  assign out_ch.last_of_packet = out_r.last_of_packet;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= vpd_pkg::FLAG_MASK_RST;
    end else if (psel && penable && pwrite && paddr[2] == vpd_pkg::REG_FLAG_MASK) begin
      mask_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == vpd_pkg::REG_FLAG_MASK) ? mask_r : '0;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < vpd_pkg::CNT_W'(vpd_pkg::MAX_VARINT_BYTES))
    else $error("varint byte count out of range");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == vpd_pkg::PH_DATA) |-> (cnt_r == '0 && acc_r == 32'd0 && rem_r != 32'd0))
    else $error("payload phase with stale varint state or no bytes left");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("skid entry lost under stall");

endmodule
